// File: rtl/gyro_rate_conditioner_defines.svh
// Assertion macros shared by the gyro rate conditioner RTL
`ifndef GYRO_RATE_CONDITIONER_DEFINES_SVH
`define GYRO_RATE_CONDITIONER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define GRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/grc_pkg.sv
// Shared types and constants for the gyro rate conditioner
package grc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_PITCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_YAW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_MODE  = 3'd6;

    // field widths
    localparam int GYRO_W   = 16;
    localparam int DT_W     = 16;
    localparam int GAIN_W   = 16;
    localparam int SMOOTH_W = 17;
    localparam int DB_W     = 15;
    localparam int ALPHA_W  = 17;
    localparam int STATE_W  = 24;
    localparam int DELTA_W  = 32;

    // axis positions
    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // alpha = 65536 - floor(y / 5), y = (19*sm + 10) >> 2, via reciprocal
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 17'd65536;
    localparam logic [18:0]         RECIP5     = 19'd419431;
    localparam int                  RECIP5_SH  = 21;

    // reset gains, Q8.8 unity
    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

    // per-lane step strobes from the sequencer
    typedef struct packed {
        logic clear;     // inactive item: zero state and result
        logic mul;       // alpha * (g<<8 - s)
        logic upd;       // s += rounded step
        logic scl_dt;    // deadbanded rate * dt
        logic scl_gain;  // * gain
        logic fin;       // sign, round, saturate
    } grc_lane_ctrl_t;

endpackage

// File: rtl/grc_if.sv
// Channel interfaces: gyro sample in, angle deltas out, register writes

interface grc_in_if import grc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     active;
    logic signed [GYRO_W-1:0] gyro_x;
    logic signed [GYRO_W-1:0] gyro_y;
    logic signed [GYRO_W-1:0] gyro_z;
    logic        [DT_W-1:0]   dt_seconds;

    modport source (output valid, active, gyro_x, gyro_y, gyro_z, dt_seconds,
                    input ready);
    modport sink   (input valid, active, gyro_x, gyro_y, gyro_z, dt_seconds,
                    output ready);
endinterface

interface grc_out_if import grc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DELTA_W-1:0] yaw_delta;
    logic signed [DELTA_W-1:0] pitch_delta;
    logic signed [DELTA_W-1:0] roll_delta;

    modport source (output valid, yaw_delta, pitch_delta, roll_delta, input ready);
    modport sink   (input valid, yaw_delta, pitch_delta, roll_delta, output ready);
endinterface

interface grc_cfg_if import grc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/grc_lane.sv
// One axis lane: moving-average update, deadband, dt and gain scaling
module grc_lane import grc_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  grc_lane_ctrl_t             ctrl,
    input  logic        [ALPHA_W-1:0]  alpha,
    input  logic        [DB_W-1:0]     deadband,
    input  logic signed [GYRO_W-1:0]   gyro,
    input  logic        [DT_W-1:0]     dt,
    input  logic        [GAIN_W-1:0]   gain,
    input  logic                       neg,
    output logic signed [DELTA_W-1:0]  result
);

    localparam int DIFF_W = STATE_W + 1;                 // 25
    localparam int PROD_W = DIFF_W + ALPHA_W + 1;        // 43
    localparam int M1_W   = STATE_W + DT_W + 1;          // 41
    localparam int P_W    = M1_W + GAIN_W + 1;           // 58
    localparam int R_W    = P_W - 18;                    // 40

    logic signed [STATE_W-1:0] s_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [M1_W-1:0]    m1_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [DELTA_W-1:0] res_reg;

    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  step_sum;
    logic signed [STATE_W-1:0] s_next;
    logic signed [STATE_W-1:0] db;
    logic signed [STATE_W-1:0] v;
    logic signed [M1_W-1:0]    m1_next;
    logic signed [P_W-1:0]     p_next;
    logic signed [P_W-1:0]     p_rnd;
    logic signed [R_W-1:0]     r_full;
    logic signed [DELTA_W-1:0] res_next;

    // error term and its weighting
    always_comb
    begin
        diff      = DIFF_W'($signed({gyro, 8'h00})) - DIFF_W'(s_reg);
        prod_next = PROD_W'($signed({1'b0, alpha}) * diff);
    end

    // round half up; the new value lies between s and g<<8, so 24 bits hold it
    always_comb
    begin
        step_sum = prod_reg + PROD_W'(32768);
        s_next   = s_reg + step_sum[STATE_W+15:16];
    end

    // strict deadband around zero
    always_comb
    begin
        db = $signed({1'b0, deadband, 8'h00});
        if ((s_reg > -db) && (s_reg < db))
            v = '0;
        else
            v = s_reg;
        m1_next = M1_W'(v * $signed({1'b0, dt}));
        p_next  = P_W'(m1_reg * $signed({1'b0, gain}));
    end

    // optional negation folded into the rounding add, then saturate
    always_comb
    begin
        if (neg)
            p_rnd = ~p_reg + P_W'(131073);
        else
            p_rnd = p_reg + P_W'(131072);
        r_full = p_rnd[P_W-1:18];
        if (r_full > R_W'(2147483647))
            res_next = 32'sh7fff_ffff;
        else if (r_full < -R_W'(64'sd2147483648))
            res_next = 32'sh8000_0000;
        else
            res_next = r_full[DELTA_W-1:0];
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_reg <= '0;
        else if (ctrl.clear)
            s_reg <= '0;
        else if (ctrl.upd)
            s_reg <= s_next;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
            prod_reg <= prod_next;
        if (ctrl.scl_dt)
            m1_reg <= m1_next;
        if (ctrl.scl_gain)
            p_reg <= p_next;
        if (ctrl.clear)
            res_reg <= '0;
        else if (ctrl.fin)
            res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

// File: rtl/gyro_rate_conditioner.sv
// Top level: config registers, step sequencer, axis lanes and result merge
//
// Gyro rate conditioner. One request on the sample channel carries a 3-axis
// rate (Q6.10 rad/s), a frame time (Q0.16 s) and an active flag; it yields
// one request on the delta channel with yaw, pitch and roll changes in Q8.24
// radians. The cfg channel writes the seven registers by index and is always
// ready; write it only while no sample is in flight.
// Each axis has its own lane; all lanes step together, driven by one
// sequencer, and a merge stage places lane results on the output fields.
// An active sample passes the five register steps of the lane (weighted
// error, state update, dt multiply, gain multiply, round and saturate)
// before it reaches the output register; an inactive one only clears the
// lane. One sample is in work at a time: a new one is accepted only once
// the sequencer has handed the last result to the output register.
// The result sits in an output register: while the receiver stalls, one
// more sample is accepted and finished, then held until the register frees.
// Reset clears the filter state, loads the register defaults (unity gains,
// no smoothing, no deadband, invert and mirror flags clear) and empties the output.
`include "gyro_rate_conditioner_defines.svh"

module gyro_rate_conditioner import grc_pkg::*; #(
    parameter int AXES = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    grc_in_if.sink     sample,
    grc_cfg_if.sink    cfg,
    grc_out_if.source  delta
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DT   = 3'd4;
    localparam logic [2:0] ST_GAIN = 3'd5;
    localparam logic [2:0] ST_RND  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    logic [SMOOTH_W-1:0] smoothing_reg;
    logic [DB_W-1:0]     deadband_reg;
    logic [GAIN_W-1:0]   sens_x_reg;
    logic [GAIN_W-1:0]   sens_y_reg;
    logic                invert_pitch_reg;
    logic                invert_yaw_reg;
    logic                mirror_mode_reg;
    logic [ALPHA_W-1:0]  alpha_reg;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic                active_reg;
    logic [DT_W-1:0]     dt_reg;
    logic signed [GYRO_W-1:0] gyro_reg [AXES];
    logic signed [GYRO_W-1:0] gyro_in  [3];

    logic                      out_valid_reg;
    logic signed [DELTA_W-1:0] yaw_reg;
    logic signed [DELTA_W-1:0] pitch_reg;
    logic signed [DELTA_W-1:0] roll_reg;

    logic                sample_acc;
    logic                out_free;
    logic                out_load;
    grc_lane_ctrl_t      lane_ctrl;
    logic signed [DELTA_W-1:0] lane_res [AXES];
    logic signed [DELTA_W-1:0] res_x;
    logic signed [DELTA_W-1:0] res_y;
    logic signed [DELTA_W-1:0] res_z;

    logic [SMOOTH_W-1:0] sm_clamp;
    logic [20:0]         sm_num;
    logic [37:0]         q_prod;
    logic [ALPHA_W-1:0]  alpha_next;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_reg    <= '0;
            deadband_reg     <= '0;
            sens_x_reg       <= GAIN_UNITY;
            sens_y_reg       <= GAIN_UNITY;
            invert_pitch_reg <= 1'b0;
            invert_yaw_reg   <= 1'b0;
            mirror_mode_reg  <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SMOOTHING:    smoothing_reg    <= cfg.data[SMOOTH_W-1:0];
                REG_DEADBAND:     deadband_reg     <= cfg.data[DB_W-1:0];
                REG_SENS_X:       sens_x_reg       <= cfg.data[GAIN_W-1:0];
                REG_SENS_Y:       sens_y_reg       <= cfg.data[GAIN_W-1:0];
                REG_INVERT_PITCH: invert_pitch_reg <= cfg.data[0];
                REG_INVERT_YAW:   invert_yaw_reg   <= cfg.data[0];
                REG_MIRROR_MODE:  mirror_mode_reg  <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // alpha = 65536 - round(0.95 * smoothing), refreshed every cycle
    always_comb
    begin
        sm_clamp   = (smoothing_reg > SMOOTH_MAX) ? SMOOTH_MAX : smoothing_reg;
        sm_num     = 21'({sm_clamp, 4'b0000}) + 21'({sm_clamp, 1'b0}) + 21'(sm_clamp)
                     + 21'd10;
        q_prod     = 38'(sm_num[20:2]) * 38'(RECIP5);
        alpha_next = SMOOTH_MAX - q_prod[RECIP5_SH+ALPHA_W-1:RECIP5_SH];
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
    end

    // sample intake
    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_acc   = sample.valid && sample.ready;
    assign gyro_in[AXIS_X] = sample.gyro_x;
    assign gyro_in[AXIS_Y] = sample.gyro_y;
    assign gyro_in[AXIS_Z] = sample.gyro_z;

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            active_reg <= sample.active;
            dt_reg     <= sample.dt_seconds;
            for (int i = 0; i < AXES; i++)
                gyro_reg[i] <= gyro_in[i];
        end
    end

    // step sequencer
    assign out_free = !out_valid_reg || delta.ready;
    assign out_load = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = sample_acc ? (sample.active ? ST_MUL : ST_CLR) : ST_IDLE;
            ST_CLR:  state_next = ST_DONE;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_DT;
            ST_DT:   state_next = ST_GAIN;
            ST_GAIN: state_next = ST_RND;
            ST_RND:  state_next = ST_DONE;
            ST_DONE: state_next = out_free ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        lane_ctrl.clear    = (state_reg == ST_CLR);
        lane_ctrl.mul      = (state_reg == ST_MUL);
        lane_ctrl.upd      = (state_reg == ST_UPD);
        lane_ctrl.scl_dt   = (state_reg == ST_DT);
        lane_ctrl.scl_gain = (state_reg == ST_GAIN);
        lane_ctrl.fin      = (state_reg == ST_RND);
    end

    // axis lanes; pitch from x (negated by default), yaw from y, roll from z
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        logic [GAIN_W-1:0] lane_gain;
        logic              lane_neg;

        assign lane_gain = (i == AXIS_Y) ? sens_y_reg : sens_x_reg;
        assign lane_neg  = (i == AXIS_X) ? !invert_pitch_reg :
                           (i == AXIS_Y) ? (invert_yaw_reg ^ mirror_mode_reg) : 1'b0;

        grc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .alpha    (alpha_reg),
            .deadband (deadband_reg),
            .gyro     (gyro_reg[i]),
            .dt       (dt_reg),
            .gain     (lane_gain),
            .neg      (lane_neg),
            .result   (lane_res[i])
        );
    end

    // merge: missing axes report zero
    assign res_x = lane_res[AXIS_X];

    if (AXES > AXIS_Y)
    begin : g_res_y
        assign res_y = lane_res[AXIS_Y];
    end
    else
    begin : g_zero_y
        assign res_y = '0;
    end

    if (AXES > AXIS_Z)
    begin : g_res_z
        assign res_z = lane_res[AXIS_Z];
    end
    else
    begin : g_zero_z
        assign res_z = '0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (delta.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            yaw_reg   <= res_y;
            pitch_reg <= res_x;
            roll_reg  <= res_z;
        end
    end

    assign delta.valid       = out_valid_reg;
    assign delta.yaw_delta   = yaw_reg;
    assign delta.pitch_delta = pitch_reg;
    assign delta.roll_delta  = roll_reg;

    // checks
    `GRC_ASSERT_NXT(a_accept_starts, sample_acc,
        (state_reg == ST_MUL) || (state_reg == ST_CLR), "sample accept did not start a step")
    `GRC_ASSERT_NXT(a_done_loads, out_load, delta.valid, "finished result not presented")
    `GRC_ASSERT_IMP(a_inactive_zero, (state_reg == ST_DONE) && !active_reg,
        (res_x == 0) && (res_y == 0) && (res_z == 0), "inactive sample gave nonzero deltas")

endmodule

// File: tb/sv/testbench.sv
// Testbench for gyro_rate_conditioner: directed and random samples checked by a fixed-point predictor
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import grc_pkg::*;

    localparam int HANG_LIMIT = 3000;
    localparam int END_WAIT   = 20;
    localparam int PHASES     = 17;

    // no register sits at this index, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [GYRO_W-1:0] RATE_MAX = 16'sh7FFF;
    localparam logic signed [GYRO_W-1:0] RATE_MIN = 16'sh8000;
    localparam logic [DT_W-1:0]          DT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic                     active;
        logic signed [GYRO_W-1:0] gx;
        logic signed [GYRO_W-1:0] gy;
        logic signed [GYRO_W-1:0] gz;
        logic [DT_W-1:0]          dt;
    } sample_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] yaw;
        logic signed [DELTA_W-1:0] pitch;
        logic signed [DELTA_W-1:0] roll;
    } deltas_t;

    logic clk;
    logic rst_n;

    grc_in_if  sample_ch ();
    grc_out_if delta_ch ();
    grc_cfg_if cfg_ch ();

    gyro_rate_conditioner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .delta  (delta_ch)
    );

    // register copies and filter state of the predictor
    logic [SMOOTH_W-1:0]       cf_smoothing;
    logic [DB_W-1:0]           cf_deadband;
    logic [GAIN_W-1:0]         cf_sens_x;
    logic [GAIN_W-1:0]         cf_sens_y;
    logic                      cf_inv_pitch;
    logic                      cf_inv_yaw;
    logic                      cf_mirror;
    logic signed [STATE_W-1:0] ema_x;
    logic signed [STATE_W-1:0] ema_y;
    logic signed [STATE_W-1:0] ema_z;

    deltas_t pending_deltas[$];
    deltas_t want;
    int      err_count;
    int      idle_cycles;
    int      hold_off;
    int      gap_max;
    int      burst_left;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic signed [STATE_W-1:0] ema_step(
        input logic signed [STATE_W-1:0] s,
        input logic signed [GYRO_W-1:0]  g,
        input longint                    alpha
    );
        longint diff;
        longint r;
        diff = longint'(g) * 256 - longint'(s);
        // round half up, floor via arithmetic shift
        r = longint'(s) + ((alpha * diff + 32768) >>> 16);
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[STATE_W-1:0];
    endfunction

    // strict deadband: a value equal to the edge passes
    function automatic longint deadbanded(input logic signed [STATE_W-1:0] s);
        longint db;
        longint v;
        db = longint'(cf_deadband) * 256;
        v  = longint'(s);
        if (v > -db && v < db)
            return 0;
        return v;
    endfunction

    // rate * dt * gain, 42 fraction bits down to Q8.24, saturated
    function automatic logic signed [DELTA_W-1:0] to_angle(
        input longint v,
        input longint dt,
        input longint gain,
        input bit     neg
    );
        longint p;
        longint r;
        p = v * dt * gain;
        if (neg)
            p = -p;
        r = (p + 131072) >>> 18;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[DELTA_W-1:0];
    endfunction

    function automatic deltas_t conditioned_deltas(input sample_t s);
        deltas_t d;
        longint  sm;
        longint  alpha;
        d = '0;
        // inactive sample clears the filter and gives zero deltas
        if (!s.active)
        begin
            ema_x = '0;
            ema_y = '0;
            ema_z = '0;
            return d;
        end
        sm    = (cf_smoothing > SMOOTH_MAX) ? longint'(SMOOTH_MAX) : longint'(cf_smoothing);
        alpha = 65536 - (sm * 19 + 10) / 20;
        ema_x = ema_step(ema_x, s.gx, alpha);
        ema_y = ema_step(ema_y, s.gy, alpha);
        ema_z = ema_step(ema_z, s.gz, alpha);
        d.pitch = to_angle(deadbanded(ema_x), s.dt, cf_sens_x, !cf_inv_pitch);
        d.yaw   = to_angle(deadbanded(ema_y), s.dt, cf_sens_y, cf_inv_yaw ^ cf_mirror);
        d.roll  = to_angle(deadbanded(ema_z), s.dt, cf_sens_x, 1'b0);
        return d;
    endfunction

    function automatic void apply_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        case (idx)
            REG_SMOOTHING:    cf_smoothing = val[SMOOTH_W-1:0];
            REG_DEADBAND:     cf_deadband  = val[DB_W-1:0];
            REG_SENS_X:       cf_sens_x    = val[GAIN_W-1:0];
            REG_SENS_Y:       cf_sens_y    = val[GAIN_W-1:0];
            REG_INVERT_PITCH: cf_inv_pitch = val[0];
            REG_INVERT_YAW:   cf_inv_yaw   = val[0];
            REG_MIRROR_MODE:  cf_mirror    = val[0];
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic signed [GYRO_W-1:0] rand_rate(
        input logic signed [GYRO_W-1:0] prev
    );
        logic signed [GYRO_W-1:0] db;
        logic signed [GYRO_W-1:0] step;
        db = GYRO_W'(cf_deadband);
        case ($urandom_range(0, 9))
            0:       return RATE_MAX;
            1:       return RATE_MIN;
            2, 3:    return GYRO_W'($urandom);
            4, 5:    return prev + GYRO_W'($urandom_range(0, 400)) - 16'sd200;
            6, 7:    return GYRO_W'($urandom_range(0, 4000)) - 16'sd2000;
            8:
            begin
                // land on or next to the deadband edge
                step = db + GYRO_W'($urandom_range(0, 2)) - 16'sd1;
                return ($urandom_range(0, 1) != 0) ? step : -step;
            end
            default: return prev;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DT_MAX;
            2, 3:    return DT_W'($urandom);
            default: return DT_W'($urandom_range(800, 1800));
        endcase
    endfunction

    // one sample request; sender runs in bursts with random gaps
    task automatic send_sample(
        input logic                     act,
        input logic signed [GYRO_W-1:0] x,
        input logic signed [GYRO_W-1:0] y,
        input logic signed [GYRO_W-1:0] z,
        input logic [DT_W-1:0]          dt
    );
        sample_t s;
        int      gap;
        s = '{act, x, y, z, dt};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_ch.valid      <= 1'b1;
        sample_ch.active     <= act;
        sample_ch.gyro_x     <= x;
        sample_ch.gyro_y     <= y;
        sample_ch.gyro_z     <= z;
        sample_ch.dt_seconds <= dt;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_deltas.push_back(conditioned_deltas(s));
    endtask

    // stop sending and wait until every delta has come back
    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_deltas.size() != 0);
        burst_left = 0;
    endtask

    // caller lowers cfg valid after the last write of a batch
    task automatic write_reg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic load_settings(input int pick);
        logic [CFG_DATA_W-1:0] sm;
        logic [CFG_DATA_W-1:0] db;
        logic [CFG_DATA_W-1:0] sx;
        logic [CFG_DATA_W-1:0] sy;
        logic [2:0]            flags;
        case (pick)
            0:
            begin
                sm    = SMOOTH_MAX;
                db    = 17'd32767;
                sx    = 17'd65535;
                sy    = 17'd65535;
                flags = 3'b111;
            end
            1:
            begin
                sm    = '0;
                db    = '0;
                sx    = '0;
                sy    = '0;
                flags = 3'b000;
            end
            default:
            begin
                sm = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(0, 65536));
                db = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(0, 1500));
                sx = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(0, 1024));
                sy = ($urandom_range(0, 2) == 0) ? CFG_DATA_W'($urandom)
                                                : CFG_DATA_W'($urandom_range(0, 1024));
                flags = 3'($urandom);
            end
        endcase
        write_reg(REG_SMOOTHING, sm);
        write_reg(REG_DEADBAND, db);
        write_reg(REG_SENS_X, sx);
        write_reg(REG_SENS_Y, sy);
        write_reg(REG_INVERT_PITCH, CFG_DATA_W'(flags[0]));
        write_reg(REG_INVERT_YAW, CFG_DATA_W'(flags[1]));
        write_reg(REG_MIRROR_MODE, CFG_DATA_W'(flags[2]));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // ---------------- tests ----------------

    // register defaults after reset: field extremes and an inactive sample
    task automatic test_reset_defaults();
        gap_max = 3;
        send_sample(1'b1, RATE_MAX, RATE_MIN, 16'sd0, DT_MAX);
        send_sample(1'b1, RATE_MIN, RATE_MAX, -16'sd1, 16'd0);
        send_sample(1'b0, -16'sd1, -16'sd1, -16'sd1, DT_MAX);
        send_sample(1'b1, 16'sd1, -16'sd1, RATE_MAX, 16'd1);
        drain_results();
    endtask

    // extreme register values, clamped smoothing, masked data, deadband edges
    task automatic test_register_extremes();
        gap_max = 3;
        // strongest smoothing, full gains: outputs saturate
        write_reg(REG_SMOOTHING, SMOOTH_MAX);
        write_reg(REG_DEADBAND, '0);
        write_reg(REG_SENS_X, 17'd65535);
        write_reg(REG_SENS_Y, 17'd65535);
        write_reg(REG_INVERT_PITCH, 17'd1);
        write_reg(REG_INVERT_YAW, 17'd1);
        write_reg(REG_MIRROR_MODE, 17'd0);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, RATE_MAX, RATE_MIN, RATE_MAX, DT_MAX);
        send_sample(1'b1, RATE_MAX, RATE_MIN, RATE_MAX, DT_MAX);
        drain_results();

        // smoothing above the top clamps; unused index and high data bits ignored
        write_reg(REG_SMOOTHING, 17'h1FFFF);
        write_reg(REG_INVERT_PITCH, 17'h1FFFE);
        write_reg(REG_INVERT_YAW, 17'd0);
        write_reg(REG_MIRROR_MODE, 17'd1);
        write_reg(REG_SENS_X, 17'h1FFFF);
        write_reg(REG_UNUSED, 17'h1FFFF);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, RATE_MIN, RATE_MAX, RATE_MIN, 16'd40000);
        send_sample(1'b0, RATE_MAX, RATE_MAX, RATE_MAX, 16'd40000);
        drain_results();

        // no smoothing, deadband of 100: values on the edge pass
        write_reg(REG_SMOOTHING, '0);
        write_reg(REG_DEADBAND, 17'd100);
        write_reg(REG_SENS_X, {1'b0, GAIN_UNITY});
        write_reg(REG_SENS_Y, {1'b0, GAIN_UNITY});
        write_reg(REG_INVERT_PITCH, 17'd1);
        write_reg(REG_INVERT_YAW, 17'd1);
        write_reg(REG_MIRROR_MODE, 17'd1);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, 16'sd100, 16'sd99, -16'sd100, DT_MAX);
        send_sample(1'b1, -16'sd99, -16'sd100, 16'sd101, DT_MAX);
        send_sample(1'b1, 16'sd0, 16'sd0, 16'sd0, DT_MAX);
        drain_results();

        // widest deadband, data bits above the field dropped
        write_reg(REG_DEADBAND, 17'h1FFFF);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, RATE_MAX, -16'sd32767, RATE_MIN, DT_MAX);
        send_sample(1'b1, 16'sd32766, 16'sd12345, -16'sd32767, DT_MAX);
        drain_results();

        // zero gains
        write_reg(REG_DEADBAND, '0);
        write_reg(REG_SENS_X, '0);
        write_reg(REG_SENS_Y, '0);
        write_reg(REG_SMOOTHING, 17'd32768);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, RATE_MIN, RATE_MAX, 16'sd12345, DT_MAX);
        drain_results();

        // smallest and largest gain, weakest nonzero smoothing
        write_reg(REG_SENS_X, 17'd1);
        write_reg(REG_SENS_Y, 17'd65535);
        write_reg(REG_SMOOTHING, 17'd1);
        write_reg(REG_INVERT_PITCH, 17'd0);
        write_reg(REG_INVERT_YAW, 17'd0);
        write_reg(REG_MIRROR_MODE, 17'd0);
        cfg_ch.valid <= 1'b0;
        send_sample(1'b1, RATE_MIN, RATE_MIN, RATE_MAX, DT_MAX);
        send_sample(1'b1, RATE_MAX, -16'sd5, 16'sd5, 16'd0);
        drain_results();
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        int i;
        gap_max  = 0;
        hold_off = 300;
        for (i = 0; i < 16; i++)
            send_sample(1'b1, rand_rate(16'sd0), rand_rate(16'sd0), rand_rate(16'sd0),
                        rand_dt());
        drain_results();
    endtask

    // phases of random settings with mostly active sample streams
    task automatic test_random_settings();
        int                       phase;
        int                       i;
        int                       n;
        logic                     act;
        logic signed [GYRO_W-1:0] x;
        logic signed [GYRO_W-1:0] y;
        logic signed [GYRO_W-1:0] z;
        x = '0;
        y = '0;
        z = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            load_settings(phase);
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1:       gap_max = 2;
                2:       gap_max = 6;
                default: gap_max = 12;
            endcase
            n = $urandom_range(30, 70);
            for (i = 0; i < n; i++)
            begin
                act = ($urandom_range(0, 11) != 0);
                x = rand_rate(x);
                y = rand_rate(y);
                z = rand_rate(z);
                send_sample(act, x, y, z, rand_dt());
            end
            drain_results();
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    // receiver stall pattern: switches among four ready modes at random
    initial
    begin
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        delta_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_off > 0)
            begin
                delta_ch.ready <= 1'b0;
                hold_off--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0:       delta_ch.ready <= 1'b1;
                    1:       delta_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       delta_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: delta_ch.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    task automatic check_field(
        input string                     what,
        input logic signed [DELTA_W-1:0] want_v,
        input logic signed [DELTA_W-1:0] got_v
    );
        if (got_v !== want_v)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endtask

    // compare each delta request with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && delta_ch.valid && delta_ch.ready)
        begin
            if (pending_deltas.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected delta request, expected none, got %0d %0d %0d",
                         $time, delta_ch.yaw_delta, delta_ch.pitch_delta,
                         delta_ch.roll_delta);
            end
            else
            begin
                want = pending_deltas.pop_front();
                check_field("yaw_delta", want.yaw, delta_ch.yaw_delta);
                check_field("pitch_delta", want.pitch, delta_ch.pitch_delta);
                check_field("roll_delta", want.roll, delta_ch.roll_delta);
            end
        end
    end

    // end the run if no channel moves a request for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (delta_ch.valid && delta_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial
    begin
        err_count  = 0;
        hold_off   = 0;
        gap_max    = 3;
        burst_left = 0;
        // predictor at reset
        cf_smoothing = '0;
        cf_deadband  = '0;
        cf_sens_x    = GAIN_UNITY;
        cf_sens_y    = GAIN_UNITY;
        cf_inv_pitch = 1'b0;
        cf_inv_yaw   = 1'b0;
        cf_mirror    = 1'b0;
        ema_x = '0;
        ema_y = '0;
        ema_z = '0;

        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.active     <= 1'b0;
        sample_ch.gyro_x     <= '0;
        sample_ch.gyro_y     <= '0;
        sample_ch.gyro_z     <= '0;
        sample_ch.dt_seconds <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= '0;
        cfg_ch.data          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_settings();

        repeat (END_WAIT) @(posedge clk);
        if (pending_deltas.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d deltas never arrived", $time, pending_deltas.size());
        end
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
